// ----- rtl/crw_pkg.sv -----
// Package for the code reachability walker: sizes, command codes, helpers.
// No dependencies.
package crw_pkg;
    localparam int MEM_WORDS   = 32768;
    localparam int STACK_DEPTH = 4096;
    localparam int AW  = $clog2(MEM_WORDS);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int SPW = SW + 1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_ENTRY = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [4:0] OP_CALL = 5'o31;
    localparam logic [4:0] OP_BRA  = 5'o34;
    localparam logic [4:0] OP_BRB  = 5'o35;
    localparam logic [4:0] OP_JMP  = 5'o30;
    localparam logic [8:0] JMP_TOP = 9'o030;

    typedef struct packed {
        logic [1:0]  command;
        logic [14:0] address;
        logic [47:0] word;
    } in_t;

    typedef struct packed {
        logic [14:0] code_start;
        logic        is_code;
        logic        stack_overflow;
    } out_t;
endpackage

// ----- rtl/crw_if.sv -----
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; payload type is a parameter.
interface crw_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/crw_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module crw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/code_reachability_walk.sv -----
// Code reachability walker, top level.
// Load and add-entry: one word per cycle while idle with no result pending, no result.
// Query: the mark is read, then S_QRD registers the result; input waits while a result
// is pending. Run: clears the 32768-entry mark memory (one entry a cycle), reads words 5
// and 010, then walks; skipped words end at S_MRK, walked ones go on to S_HALF and S_TBL.
// Reset (rst_n, async low) clears control, stack pointer and the register, then MEM_WORDS.
module code_reachability_walk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,
    crw_if.sink         in_ch,
    crw_if.source       out_ch
);
    import crw_pkg::*;

    typedef enum logic [11:0] {
        S_CLR  = 12'b000000000001,
        S_IDLE = 12'b000000000010,
        S_QRD  = 12'b000000000100,
        S_R5   = 12'b000000001000,
        S_R10  = 12'b000000010000,
        S_POP  = 12'b000000100000,
        S_PWT  = 12'b000001000000,
        S_MRK  = 12'b000010000000,
        S_WRD  = 12'b000100000000,
        S_HALF = 12'b001000000000,
        S_TBL  = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } st_t;

    st_t            st_reg, st_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [14:0]    len_reg, len_next, low_reg, low_next, cur_reg, cur_next;
    logic [14:0]    tbl_reg, tbl_next, forced_reg;
    logic           ovf_reg, ovf_next, half_reg, half_next, run_reg, run_next;
    logic [47:0]    w_reg, w_next;
    out_t           res_reg, res_next;
    logic           ovld_reg, ovld_next;
    logic [1:0]     tsub_reg, tsub_next;

    // word store port
    logic          ws_we;
    logic [AW-1:0] ws_addr;
    logic [47:0]   ws_rd;
    // mark port
    logic          mk_we, mk_wd, mk_rd;
    logic [AW-1:0] mk_addr;
    // stack port
    logic          sk_we;
    logic [SW-1:0] sk_addr;
    logic [14:0]   sk_wd, sk_rd;

    crw_ram #(.WIDTH(48), .DEPTH(MEM_WORDS)) u_words (
        .clk(clk), .we(ws_we), .addr(ws_addr), .wdata(in_ch.data.word), .rdata(ws_rd));
    crw_ram #(.WIDTH(1), .DEPTH(MEM_WORDS)) u_marks (
        .clk(clk), .we(mk_we), .addr(mk_addr), .wdata(mk_wd), .rdata(mk_rd));
    crw_ram #(.WIDTH(15), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(sk_we), .addr(sk_addr), .wdata(sk_wd), .rdata(sk_rd));

    // decode of current half
    logic [23:0] h;
    logic [4:0]  op;
    logic [3:0]  rg;
    logic [14:0] tgt, nxt;
    assign h   = half_reg ? w_reg[23:0] : w_reg[47:24];
    assign op  = h[19:15];
    assign rg  = h[23:20];
    assign tgt = h[14:0];
    assign nxt = cur_reg + 15'd1;

    logic in_mem;
    assign in_mem = ({1'b0, in_ch.data.address} < 16'(MEM_WORDS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            forced_reg <= '0;
        else if (cfg_we)
            forced_reg <= cfg_wdata;
    end

    // push helpers: up to two pushes per half are done over sub-steps (tsub)
    logic          push_en;
    logic [14:0]   push_val;

    always_comb
    begin
        st_next = st_reg; clr_next = clr_reg; sp_next = sp_reg; len_next = len_reg;
        low_next = low_reg; cur_next = cur_reg; tbl_next = tbl_reg; ovf_next = ovf_reg;
        half_next = half_reg; run_next = run_reg; w_next = w_reg; res_next = res_reg;
        ovld_next = ovld_reg; tsub_next = tsub_reg;
        ws_we = 1'b0; ws_addr = in_ch.data.address[AW-1:0];
        mk_we = 1'b0; mk_wd = 1'b0; mk_addr = in_ch.data.address[AW-1:0];
        sk_we = 1'b0; sk_addr = sp_reg[SW-1:0]; sk_wd = in_ch.data.address;
        push_en = 1'b0; push_val = '0;
        in_ch.ready = 1'b0;

        if (ovld_reg && out_ch.ready)
            ovld_next = 1'b0;

        unique case (st_reg)
            S_CLR:
            begin
                mk_we = 1'b1; mk_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(MEM_WORDS - 1))
                    st_next = run_reg ? S_R5 : S_IDLE;
            end
            S_IDLE:
            begin
                in_ch.ready = !ovld_reg;
                if (in_ch.valid && in_ch.ready)
                begin
                    unique case (in_ch.data.command)
                        CMD_LOAD: ws_we = in_mem;
                        CMD_ENTRY:
                        begin
                            // slot 0 kept for the main entry
                            if (sp_reg == '0)
                            begin
                                sk_addr = SW'(1);
                                push_en = 1'b1; push_val = in_ch.data.address;
                            end
                            else
                            begin
                                push_en = 1'b1; push_val = in_ch.data.address;
                            end
                        end
                        CMD_RUN:
                        begin
                            run_next = 1'b1; clr_next = '0; st_next = S_CLR;
                        end
                        CMD_QUERY:
                        begin
                            tbl_next = {14'd0, in_mem}; st_next = S_QRD;
                        end
                        default: ;
                    endcase
                end
            end
            S_QRD:
            begin
                res_next = '{code_start: 15'd0, is_code: mk_rd & tbl_reg[0],
                             stack_overflow: 1'b0};
                ovld_next = 1'b1; st_next = S_IDLE;
            end
            S_R5:
            begin
                ws_addr = AW'(5);
                tsub_next = 2'd0;
                st_next = S_R10;
            end
            S_R10:
            begin
                len_next = ws_rd[14:0]; low_next = ws_rd[14:0];
                ws_addr = AW'(8);
                tsub_next = 2'd1;
                if (tsub_reg == 2'd1)
                begin
                    // word 010 data now present
                    sk_we = 1'b1; sk_addr = '0; sk_wd = ws_rd[14:0];
                    len_next = len_reg; low_next = low_reg;
                    if (sp_reg == '0)
                        sp_next = SPW'(1);
                    tsub_next = 2'd0;
                    st_next = S_POP;
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    res_next = '{code_start: (forced_reg != 0) ? forced_reg : low_reg,
                                 is_code: 1'b0, stack_overflow: ovf_reg};
                    ovf_next = 1'b0; run_next = 1'b0;
                    st_next = S_OUT;
                end
                else
                begin
                    sp_next = sp_reg - 1'b1;
                    sk_addr = SW'(sp_reg - 1'b1);
                    st_next = S_PWT;
                end
            end
            S_PWT:
            begin
                cur_next = sk_rd;
                mk_addr = sk_rd[AW-1:0];
                ws_addr = sk_rd[AW-1:0];
                st_next = S_MRK;
            end
            S_MRK:
            begin
                mk_addr = cur_reg[AW-1:0];
                if (cur_reg >= len_reg || {1'b0, cur_reg} >= 16'(MEM_WORDS) || mk_rd)
                    st_next = S_POP;
                else
                begin
                    mk_we = 1'b1; mk_wd = 1'b1;
                    if (cur_reg < low_reg)
                        low_next = cur_reg;
                    w_next = ws_rd; half_next = 1'b0; tsub_next = 2'd0;
                    st_next = S_HALF;
                end
            end
            S_HALF:
            begin
                // tsub 0: first push, tsub 1: second push
                if (op == OP_CALL || op == OP_BRA || op == OP_BRB)
                begin
                    if (tsub_reg == 2'd0)
                    begin
                        push_en = (tgt != 0) && (tgt < len_reg); push_val = tgt;
                        tsub_next = 2'd1;
                    end
                    else
                    begin
                        push_en = 1'b1; push_val = nxt; st_next = S_POP;
                    end
                end
                else if (op == OP_JMP)
                begin
                    if (tgt < len_reg && rg == 0)
                    begin
                        push_en = 1'b1; push_val = tgt; st_next = S_POP;
                    end
                    else if ((tgt == cur_reg || tgt == nxt) && rg != 0)
                    begin
                        tbl_next = tgt; tsub_next = 2'd0; st_next = S_TBL;
                    end
                    else
                        st_next = S_POP;
                end
                else
                begin
                    if (tsub_reg == 2'd0)
                    begin
                        if ((h & 24'o77600000) == 24'o02600000 ||
                            (h & 24'o77700000) == 24'o42600000)
                        begin
                            push_en = tgt < len_reg; push_val = tgt;
                        end
                        tsub_next = 2'd1;
                    end
                    else
                    begin
                        if (half_reg)
                        begin
                            push_en = 1'b1; push_val = nxt; st_next = S_POP;
                        end
                        else
                        begin
                            half_next = 1'b1;
                        end
                        tsub_next = 2'd0;
                    end
                end
            end
            S_TBL:
            begin
                // tsub 0: issue read, 1: wait, 2: test and push
                ws_addr = tbl_reg[AW-1:0];
                if (tsub_reg == 2'd0)
                begin
                    if (tbl_reg >= len_reg)
                        st_next = S_POP;
                    else
                        tsub_next = 2'd1;
                end
                else if (tsub_reg == 2'd1)
                    tsub_next = 2'd2;
                else
                begin
                    tsub_next = 2'd0;
                    if ({1'b0, tbl_reg} < 16'(MEM_WORDS) && ws_rd[47:39] == JMP_TOP)
                    begin
                        push_en = 1'b1; push_val = tbl_reg; tbl_next = tbl_reg + 15'd1;
                    end
                    else
                        st_next = S_POP;
                end
            end
            S_OUT:
            begin
                if (!ovld_reg)
                begin
                    ovld_next = 1'b1; sp_next = '0; st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase

        // common push path; overflow when full
        if (push_en)
        begin
            if (sp_reg == SPW'(STACK_DEPTH) ||
                (st_reg == S_IDLE && sp_reg == '0 && STACK_DEPTH < 2))
                ovf_next = 1'b1;
            else
            begin
                sk_we = 1'b1; sk_wd = push_val;
                if (!(st_reg == S_IDLE && sp_reg == '0))
                    sk_addr = sp_reg[SW-1:0];
                sp_next = (sp_reg == '0 && st_reg == S_IDLE) ? SPW'(2) : sp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLR; clr_reg <= '0; sp_reg <= '0; len_reg <= '0; low_reg <= '0;
            ovf_reg <= 1'b0; run_reg <= 1'b0; ovld_reg <= 1'b0; tsub_reg <= '0;
            half_reg <= 1'b0; tbl_reg <= '0;
        end
        else
        begin
            st_reg <= st_next; clr_reg <= clr_next; sp_reg <= sp_next;
            len_reg <= len_next; low_reg <= low_next; ovf_reg <= ovf_next;
            run_reg <= run_next; ovld_reg <= ovld_next; tsub_reg <= tsub_next;
            half_reg <= half_next; tbl_reg <= tbl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next; w_reg <= w_next; res_reg <= res_next;
    end

    assign out_ch.valid = ovld_reg;
    assign out_ch.data  = res_reg;
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Testbench for code_reachability_walk: directed and random load/entry/run/query words.
// Depends on crw_pkg (rtl/crw_pkg.sv), crw_if (rtl/crw_if.sv) and code_reachability_walk.
module tb;
    import crw_pkg::*;

    localparam int          LIMIT_CYCLES = 20000000;
    localparam int          PROG_WORDS   = 64;      // words 0..63 hold the program image
    localparam logic [23:0] ZB_A_MASK    = 24'o77600000;
    localparam logic [23:0] ZB_A_VAL     = 24'o02600000;
    localparam logic [23:0] ZB_B_MASK    = 24'o77700000;
    localparam logic [23:0] ZB_B_VAL     = 24'o42600000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [14:0] cfg_wdata;

    crw_if #(.T(in_t))  in_ch ();
    crw_if #(.T(out_t)) out_ch ();

    code_reachability_walk uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Shadow of the block: word store, marks, worklist, sticky flags.
    logic [47:0] mem_image [0:MEM_WORDS-1];
    bit          mark_image [0:MEM_WORDS-1];
    logic [14:0] work_list [0:STACK_DEPTH-1];
    int          wl_depth;
    bit          ovf_seen;
    logic [14:0] forced_start;
    out_t        pending_results [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_left;       // receiver hold-off, counted down by the receiver process
    int  mismatches;
    int  cycle_count;
    int  random_words;

    always #5 clk = ~clk;

    // Watchdog: a hung walk must not run forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus long hold-offs on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: %p", out_ch.data);
                mismatches++;
            end
            else
            begin
                out_t exp_r;
                exp_r = pending_results.pop_front();
                if (out_ch.data.code_start !== exp_r.code_start)
                begin
                    $error("code_start expected %0d actual %0d",
                           exp_r.code_start, out_ch.data.code_start);
                    mismatches++;
                end
                if (out_ch.data.is_code !== exp_r.is_code)
                begin
                    $error("is_code expected %0d actual %0d",
                           exp_r.is_code, out_ch.data.is_code);
                    mismatches++;
                end
                if (out_ch.data.stack_overflow !== exp_r.stack_overflow)
                begin
                    $error("stack_overflow expected %0d actual %0d",
                           exp_r.stack_overflow, out_ch.data.stack_overflow);
                    mismatches++;
                end
            end
        end
    end

    // ---------------- predictor ----------------

    // Worklist push; a full list drops the address and flags it.
    function automatic void push_work(int a);
        if (wl_depth >= STACK_DEPTH)
            ovf_seen = 1'b1;
        else
        begin
            work_list[wl_depth] = a[14:0];
            wl_depth++;
        end
    endfunction

    // Reachability walk over the shadow store; returns the lowest reached address.
    function automatic logic [14:0] walk_image();
        int          len;
        int          low;
        int          cur;
        logic [47:0] w;
        logic [23:0] h;
        logic [4:0]  op;
        logic [3:0]  rg;
        int          tgt;
        len = mem_image[5][14:0];
        low = len;
        for (int a = 0; a < MEM_WORDS; a++)
            mark_image[a] = 1'b0;
        // slot 0 is kept for the main entry, under all added entries
        work_list[0] = mem_image[8][14:0];
        if (wl_depth == 0)
            wl_depth = 1;
        while (wl_depth > 0)
        begin
            wl_depth--;
            cur = work_list[wl_depth];
            if (cur >= len || mark_image[cur])
                continue;
            mark_image[cur] = 1'b1;
            if (cur < low)
                low = cur;
            w = mem_image[cur];
            for (int i = 0; i < 2; i++)
            begin
                h   = (i == 0) ? w[47:24] : w[23:0];
                op  = h[19:15];
                rg  = h[23:20];
                tgt = h[14:0];
                if (op == OP_CALL || op == OP_BRA || op == OP_BRB)
                begin
                    if (tgt != 0 && tgt < len)
                        push_work(tgt);
                    push_work(cur + 1);
                    break;
                end
                else if (op == OP_JMP)
                begin
                    if (tgt < len && rg == 0)
                        push_work(tgt);
                    else if ((tgt == cur || tgt == cur + 1) && rg != 0)
                    begin
                        // jump table: consecutive jump words from the target on
                        for (int t = tgt; t < len; t++)
                        begin
                            if (mem_image[t][47:39] == JMP_TOP)
                                push_work(t);
                            else
                                break;
                        end
                    end
                    break;
                end
                else if ((h & ZB_A_MASK) == ZB_A_VAL || (h & ZB_B_MASK) == ZB_B_VAL)
                begin
                    if (tgt < len)
                        push_work(tgt);
                    if (i == 1)
                        push_work(cur + 1);
                end
                else if (i == 1)
                    push_work(cur + 1);
            end
        end
        return low[14:0];
    endfunction

    // Apply one accepted word to the shadow and queue its result, if any.
    function automatic void predict_word(in_t it);
        out_t        r;
        logic [14:0] low;
        case (it.command)
            CMD_LOAD:
                mem_image[it.address] = it.word;
            CMD_ENTRY:
            begin
                if (wl_depth == 0)
                    wl_depth = 1;
                push_work(it.address);
            end
            CMD_RUN:
            begin
                low = walk_image();
                r.code_start     = (forced_start != 0) ? forced_start : low;
                r.is_code        = 1'b0;
                r.stack_overflow = ovf_seen;
                ovf_seen = 1'b0;
                wl_depth = 0;
                pending_results = {pending_results, r};
            end
            default:
            begin
                r.code_start     = '0;
                r.is_code        = mark_image[it.address];
                r.stack_overflow = 1'b0;
                pending_results = {pending_results, r};
            end
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------

    // Send one word; valid stays high into the next word unless a gap is drawn.
    task automatic send_word(logic [1:0] cmd, logic [14:0] addr, logic [47:0] w);
        in_t it;
        int  gap;
        it.command = cmd;
        it.address = addr;
        it.word    = w;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_word(it);
        random_words++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lower valid right after the last word, then wait for all results.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);   // loads and entries leave no result to wait on
    endtask

    task automatic write_forced(logic [14:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        forced_start = v;
        @(posedge clk);
    endtask

    // One instruction half: calls, jumps, jump-table heads, zero-reg branches, noise.
    function automatic logic [23:0] make_half(int a, int plen);
        logic [14:0] tgt;
        logic [4:0]  op;
        tgt = 15'($urandom_range(0, plen + 1));
        case ($urandom_range(0, 8))
            0:
            begin
                case ($urandom_range(0, 2))
                    0: op = OP_CALL;
                    1: op = OP_BRA;
                    default: op = OP_BRB;
                endcase
                return {4'($urandom), op, tgt};
            end
            1, 2: return {4'd0, OP_JMP, tgt};
            3: return {4'($urandom_range(1, 15)), OP_JMP, 15'(a + $urandom_range(0, 1))};
            4: return ZB_A_VAL | {8'd0, 1'($urandom), tgt};
            5: return ZB_B_VAL | {9'd0, tgt};
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] make_word(int a, int plen);
        if ($urandom_range(0, 9) == 0)
            return {16'($urandom), 32'($urandom)};
        return {make_half(a, plen), make_half(a, plen)};
    endfunction

    // Length word and main entry word keep random upper bits.
    task automatic load_length(int plen);
        send_word(CMD_LOAD, 15'd5, {16'($urandom), 17'($urandom), 15'(plen)});
    endtask

    task automatic load_entry_word(int plen);
        send_word(CMD_LOAD, 15'd8, {16'($urandom), 17'($urandom), 15'($urandom_range(0, plen + 4))});
    endtask

    // A well-formed round: program image, extra entries, run, queries of the marks.
    task automatic program_round(bit full);
        int plen;
        plen = mem_image[5][14:0];
        if (full)
        begin
            case ($urandom_range(0, 9))
                0: plen = 0;
                1: plen = PROG_WORDS;
                default: plen = $urandom_range(9, PROG_WORDS);
            endcase
            for (int a = 0; a < PROG_WORDS; a++)
            begin
                if (a == 5)
                    load_length(plen);
                else if (a == 8)
                    load_entry_word(plen);
                else
                    send_word(CMD_LOAD, 15'(a), make_word(a, plen));
            end
        end
        else
        begin
            repeat ($urandom_range(2, 10))
            begin
                int a;
                a = $urandom_range(0, PROG_WORDS - 1);
                if (a == 5)
                    load_length(plen);
                else if (a == 8)
                    load_entry_word(plen);
                else
                    send_word(CMD_LOAD, 15'(a), make_word(a, plen));
            end
            // noise far above the program; never read by the walk
            send_word(CMD_LOAD, 15'($urandom_range(PROG_WORDS, 32767)),
                      {16'($urandom), 32'($urandom)});
        end
        repeat ($urandom_range(0, 4))
            send_word(CMD_ENTRY, ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                 : 15'($urandom_range(0, plen + 1)), 48'($urandom));
        send_word(CMD_RUN, 15'($urandom), {16'($urandom), 32'($urandom)});
        repeat ($urandom_range(3, 10))
            send_word(CMD_QUERY, ($urandom_range(0, 4) == 0) ? 15'($urandom)
                                 : 15'($urandom_range(0, PROG_WORDS + 8)), 48'($urandom));
    endtask

    // ---------------- tests ----------------

    // Hand-built program of length 12 exercising each instruction rule.
    task automatic test_directed();
        send_word(CMD_LOAD, 15'd0, 48'h0);                                   // falls through
        send_word(CMD_LOAD, 15'd1, {4'd0, OP_CALL, 15'd3, 24'h0});           // call
        send_word(CMD_LOAD, 15'd2, {4'd0, OP_JMP, 15'd7, 24'h0});            // plain jump
        send_word(CMD_LOAD, 15'd3, {ZB_A_VAL | 24'd9, 24'h0});               // zero-reg branch
        send_word(CMD_LOAD, 15'd4, {4'd1, OP_JMP, 15'd5, 24'h0});            // jump table head
        send_word(CMD_LOAD, 15'd5, {4'd0, OP_JMP, 15'd6, 24'd12});           // table word, length 12
        send_word(CMD_LOAD, 15'd6, {4'd0, OP_JMP, 15'd0, 24'h0});            // table word
        send_word(CMD_LOAD, 15'd7, {24'h0, ZB_B_VAL | 24'd11});              // low half branch
        send_word(CMD_LOAD, 15'd8, {ZB_B_VAL | 24'd10, 24'd1});              // main entry = 1
        send_word(CMD_LOAD, 15'd9, 48'hFFFF_FFFF_FFFF);
        send_word(CMD_LOAD, 15'd10, {24'h123456, 4'd0, OP_BRA, 15'd0});
        send_word(CMD_LOAD, 15'd11, {4'hF, OP_BRB, 15'd11, 24'h0});          // next word past length
        send_word(CMD_LOAD, 15'd32767, 48'hFFFF_FFFF_FFFF);
        send_word(CMD_ENTRY, 15'd4, 48'h0);
        send_word(CMD_ENTRY, 15'd32767, 48'hFFFF_FFFF_FFFF);                 // out of range, skipped
        send_word(CMD_RUN, 15'd0, 48'h0);
        send_word(CMD_QUERY, 15'd0, 48'h0);
        send_word(CMD_QUERY, 15'd4, 48'h0);
        send_word(CMD_QUERY, 15'd11, 48'h0);
        send_word(CMD_QUERY, 15'd12, 48'h0);
        send_word(CMD_QUERY, 15'd32767, 48'h0);
        drain_results();
        write_forced(15'd32767);
        send_word(CMD_RUN, 15'd32767, 48'hFFFF_FFFF_FFFF);                   // forced start reported
        drain_results();
        write_forced(15'd0);
    endtask

    // Many added entries stacked over the main entry, then two runs back to back.
    task automatic test_deep_worklist();
        repeat (200)
            send_word(CMD_ENTRY, 15'($urandom_range(0, PROG_WORDS + 8)), 48'($urandom));
        send_word(CMD_RUN, 15'd0, 48'h0);
        send_word(CMD_RUN, 15'd0, 48'h0);     // second run starts from an empty list
        drain_results();
    endtask

    // Receiver holds off while queries keep coming, then the sender waits for all.
    task automatic test_backpressure();
        hold_left = 400;
        repeat (120)
            send_word(CMD_QUERY, 15'($urandom_range(0, PROG_WORDS)), 48'($urandom));
        drain_results();
    endtask

    task automatic test_random_phase(int s_pct, int r_pct, int quota, logic [14:0] forced);
        int start_count;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_forced(forced);
        start_count = random_words;
        program_round(1'b1);
        while (random_words - start_count < quota)
            program_round($urandom_range(0, 2) == 0);
        drain_results();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        hold_left      = 0;
        mismatches     = 0;
        cycle_count    = 0;
        random_words   = 0;
        wl_depth       = 0;
        ovf_seen       = 1'b0;
        forced_start   = '0;
        send_idle_pct  = 18;
        recv_idle_pct  = 83;
        for (int a = 0; a < MEM_WORDS; a++)
            mark_image[a] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(18, 83, 230, 15'd0);
        test_deep_worklist();
        test_random_phase(83, 18, 230, 15'($urandom_range(1, 32766)));
        test_backpressure();
        test_random_phase(0, 0, 230, 15'd1);
        write_forced(15'd0);
        program_round(1'b0);
        drain_results();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/crw_pkg.sv
rtl/crw_if.sv
rtl/crw_ram.sv
rtl/code_reachability_walk.sv
tb/sv/tb.sv
